// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

	localparam int WORD_W    = 32;
	localparam int MSS_W     = 16;
	localparam int COUNT_W   = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [MSS_W-1:0]   MSS_RESET     = MSS_W'(536);
	localparam logic [COUNT_W-1:0] DUP_THR_RESET = COUNT_W'(3);
	localparam logic [WORD_W-1:0]  WINDOW_RESET  = WORD_W'(4380);
	localparam logic [WORD_W-1:0]  THRESH_RESET  = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MSS      = 2'd0,
		CFG_DUP_THR  = 2'd1,
		CFG_INIT_WIN = 2'd2,
		CFG_INIT_THR = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic [WORD_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		sat_add = sum[WORD_W] ? '1 : sum[WORD_W-1:0];
	endfunction

endpackage

// ===== rtl/tcw_div.sv =====
module tcw_div
	import tcw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	output logic              done,
	output logic [WORD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(WORD_W);

	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [WORD_W:0]   shifted;
	logic [WORD_W:0]   diff;
	logic              fits;

	// one quotient bit per cycle; dividend bits leave the top as quotient bits enter below
	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[WORD_W-2:0], fits};
			rem_q <= fits ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/tcp_congestion_window_update.sv =====
// TCP Reno congestion window engine (sender side). Each accepted ACK event
// yields one result with the window and slow start threshold after the event
// and a retransmit flag. Events are handled one at a time. Slow start, loss
// recovery and duplicate ACKs go from the execute state to the result
// register. A congestion avoidance ACK goes from the execute state through
// the divide and finish states; the radix-2 divider forms MSS*MSS/window one
// quotient bit per cycle, from its start through its quotient bits to done,
// and the finish state then writes the result. A stalled output holds the
// result back until the output slot is free. A new event is taken while an
// earlier result still waits at the output. Reset loads a window of 4380
// bytes and an all-ones threshold; writes to the initial window and
// threshold indices are ignored, and reset always restores those defaults.
module tcp_congestion_window_update
	import tcw_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic                 in_loss_recovery,
	input  logic [COUNT_W-1:0]   dup_ack_count,
	input  logic [WORD_W-1:0]    bytes_in_flight,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_W-1:0]    window,
	output logic [WORD_W-1:0]    threshold,
	output logic                 retransmit
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_FIN
	} state_t;

	state_t             state_q;

	logic [MSS_W-1:0]   mss_q;
	logic [COUNT_W-1:0] dup_thr_q;

	logic [WORD_W-1:0]  cwnd_q;
	logic [WORD_W-1:0]  ssth_q;

	logic               command_q;
	logic               loss_q;
	logic [COUNT_W-1:0] count_q;
	logic [WORD_W-1:0]  flight_q;

	logic               out_valid_q;
	logic [WORD_W-1:0]  window_q;
	logic [WORD_W-1:0]  threshold_q;
	logic               retransmit_q;

	div_req_t           div_req;
	logic               div_done;
	logic [WORD_W-1:0]  div_quotient;

	logic               slot_free;
	logic               res_write;
	logic [WORD_W-1:0]  res_window;
	logic [WORD_W-1:0]  res_thr;
	logic               res_retx;

	logic [WORD_W-1:0]  mss_w;
	logic [WORD_W-1:0]  half_flight;
	logic [WORD_W-1:0]  floor_thr;
	logic [WORD_W-1:0]  recov_thr;
	logic [WORD_W-1:0]  three_mss;
	logic [WORD_W-1:0]  ca_inc;

	tcw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q     <= MSS_RESET;
			dup_thr_q <= DUP_THR_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_MSS:     mss_q     <= cfg_data[MSS_W-1:0];
				CFG_DUP_THR: dup_thr_q <= cfg_data[COUNT_W-1:0];
				// initial values only matter at reset, which restores the defaults
				CFG_INIT_WIN: ;
				CFG_INIT_THR: ;
				default: ;
			endcase
		end
	end

	assign slot_free   = !out_valid_q || !out_stall;
	assign mss_w       = WORD_W'(mss_q);
	assign half_flight = {1'b0, flight_q[WORD_W-1:1]};
	assign floor_thr   = WORD_W'({mss_q, 1'b0});
	assign recov_thr   = (half_flight > floor_thr) ? half_flight : floor_thr;
	assign three_mss   = floor_thr + mss_w;
	assign ca_inc      = (div_quotient == '0) ? WORD_W'(1) : div_quotient;

	always_comb begin
		res_write        = 1'b0;
		res_window       = cwnd_q;
		res_thr          = ssth_q;
		res_retx         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = mss_w * mss_w;
		div_req.divisor  = cwnd_q;
		case (state_q)
			S_EXEC: begin
				if (!command_q) begin
					if (loss_q) begin
						res_write = slot_free;
					end else if (cwnd_q < ssth_q) begin
						res_window = sat_add(cwnd_q, mss_w);
						res_write  = slot_free;
					end else begin
						div_req.start = 1'b1;
					end
				end else begin
					if (count_q == dup_thr_q) begin
						res_thr    = recov_thr;
						res_window = sat_add(recov_thr, three_mss);
						res_retx   = 1'b1;
					end else if (count_q > dup_thr_q) begin
						res_window = sat_add(cwnd_q, mss_w);
					end
					res_write = slot_free;
				end
			end
			S_FIN: begin
				res_window = sat_add(cwnd_q, ca_inc);
				res_write  = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cwnd_q       <= WINDOW_RESET;
			ssth_q       <= THRESH_RESET;
			command_q    <= 1'b0;
			loss_q       <= 1'b0;
			count_q      <= '0;
			flight_q     <= '0;
			out_valid_q  <= 1'b0;
			window_q     <= '0;
			threshold_q  <= '0;
			retransmit_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						command_q <= command;
						loss_q    <= in_loss_recovery;
						count_q   <= dup_ack_count;
						flight_q  <= bytes_in_flight;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (div_req.start) begin
						state_q <= S_DIV;
					end else if (res_write) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (res_write) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// hold the result until taken; a new one only lands in a free slot
			if (res_write) begin
				cwnd_q       <= res_window;
				ssth_q       <= res_thr;
				window_q     <= res_window;
				threshold_q  <= res_thr;
				retransmit_q <= res_retx;
				out_valid_q  <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign window     = window_q;
	assign threshold  = threshold_q;
	assign retransmit = retransmit_q;

`ifndef NO_ASSERTIONS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_avoid_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cwnd_q >= ssth_q)
		else $error("divide running while in slow start");

	a_retx_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && retransmit_q |-> threshold_q >= WORD_W'({mss_q, 1'b0}))
		else $error("retransmit threshold below two segments");

	a_fin_writes: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && slot_free |=> out_valid_q && state_q == S_IDLE)
		else $error("divide result not delivered to the output");
`endif

endmodule
